/* sv/text_console_writer_defines.svh */
// Assertion helpers for the text console writer.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle check, sampled on clk, off while rst is high.
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle check, sampled on clk, off while rst is high.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/tcw_pkg.sv */
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int SUM_W  = ADDR_W + 1;

  // field widths
  localparam int KIND_W = 2;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 11;
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_BLANK_ATTR = 1'b0;  // register index, paddr[2]

  // request kinds
  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // character codes
  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

  localparam logic [BYTE_W-1:0] RESET_ATTR = 8'h07;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_RDATA,
    ST_FILL,
    ST_DONE
  } tcw_state_t;

endpackage

`default_nettype wire

/* sv/text_console_writer.sv */
// Text console writer: put / read / clear requests against a rotating screen store.
// Flow: a put passes accept, execute and result states; a read adds a read-data state;
//   a put or newline that scrolls also blanks the new bottom row of COLUMNS cells;
//   clear blanks all ROWS*COLUMNS cells. A new request is taken only in idle, so not
//   before any fill sweep ends and the result register has taken the last result.
// Reset: synchronous rst; afterwards a clearing pass writes space/0x07 to every
//   cell, and s_tready stays low until it is done.
`default_nettype none
`include "text_console_writer_defines.svh"

module text_console_writer (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // slave request: [1:0] kind, [9:2] char_code, [17:10] attribute,
  // [28:18] cell_index, [31:29] zero
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [31:0]                 s_tdata,
  // master result: [10:0] cursor_position, [26:11] cell_value, [31:27] zero
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic      [31:0]                 m_tdata,
  // configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tcw_pkg::PADDR_W-1:0] paddr,
  input  wire logic [tcw_pkg::PDATA_W-1:0] pwdata,
  output logic      [tcw_pkg::PDATA_W-1:0] prdata,
  output logic                             pready
);
  import tcw_pkg::*;

  // Screen rows are stored rotated: logical row 0 starts at physical cell
  // top_base. Scrolling advances top_base one row and blanks only the row that
  // wraps around to the bottom, instead of copying the whole store.

  logic [BYTE_W-1:0] blank_attribute;

  tcw_apb_regs u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .blank_attribute (blank_attribute)
  );

  // ---------------- cell store ----------------
  logic [CELL_W-1:0] cell_mem [CELL_COUNT];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= cell_mem[mem_raddr];
  end

  // ---------------- registers ----------------
  tcw_state_t        state, state_next;
  logic [COL_W-1:0]  cursor_column, cursor_column_next;
  logic [ROW_W-1:0]  cursor_row, cursor_row_next;
  logic [ADDR_W-1:0] top_base, top_base_next;
  logic [ADDR_W-1:0] fill_addr, fill_addr_next;
  logic [ADDR_W-1:0] fill_cnt, fill_cnt_next;
  logic [CELL_W-1:0] fill_data, fill_data_next;
  logic [CELL_W-1:0] cell_value, cell_value_next;

  // request held for execution
  logic [KIND_W-1:0] req_kind;
  logic [BYTE_W-1:0] req_char;
  logic [BYTE_W-1:0] req_attr;
  logic [IDX_W-1:0]  req_index;

  logic accept;
  logic out_load;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind  <= s_tdata[1:0];
      req_char  <= s_tdata[9:2];
      req_attr  <= s_tdata[17:10];
      req_index <= s_tdata[28:18];
    end
  end

  // ---------------- address mapping ----------------
  logic [ADDR_W-1:0] cur_lin;
  logic [ADDR_W-1:0] target_lin;
  logic [SUM_W-1:0]  phys_sum;
  logic [ADDR_W-1:0] phys_addr;
  logic [SUM_W-1:0]  top_sum;
  logic [ADDR_W-1:0] top_adv;
  logic              idx_ok;
  logic              is_bs;

  assign cur_lin = ADDR_W'(cursor_row) * ADDR_W'(COLUMNS) + ADDR_W'(cursor_column);
  assign idx_ok  = ({1'b0, req_index} < (IDX_W + 1)'(CELL_COUNT));
  assign is_bs   = (req_char == CH_BS);

  always_comb begin
    if (req_kind == KIND_READ) begin
      target_lin = ADDR_W'(req_index);
    end else if (is_bs) begin
      target_lin = cur_lin - ADDR_W'(1);  // only used when the column is nonzero
    end else begin
      target_lin = cur_lin;
    end
  end

  assign phys_sum  = SUM_W'(target_lin) + SUM_W'(top_base);
  assign phys_addr = (phys_sum >= SUM_W'(CELL_COUNT)) ?
                     ADDR_W'(phys_sum - SUM_W'(CELL_COUNT)) : ADDR_W'(phys_sum);

  assign top_sum = SUM_W'(top_base) + SUM_W'(COLUMNS);
  assign top_adv = (top_sum >= SUM_W'(CELL_COUNT)) ?
                   ADDR_W'(top_sum - SUM_W'(CELL_COUNT)) : ADDR_W'(top_sum);

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    logic row_adv;
    row_adv            = 1'b0;
    state_next         = state;
    cursor_column_next = cursor_column;
    cursor_row_next    = cursor_row;
    top_base_next      = top_base;
    fill_addr_next     = fill_addr;
    fill_cnt_next      = fill_cnt;
    fill_data_next     = fill_data;
    cell_value_next    = cell_value;
    mem_we             = 1'b0;
    mem_waddr          = phys_addr;
    mem_wdata          = {req_attr, req_char};
    mem_raddr          = phys_addr;
    out_load           = 1'b0;

    case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = fill_addr;
        mem_wdata = fill_data;
        fill_addr_next = fill_addr + ADDR_W'(1);
        fill_cnt_next  = fill_cnt - ADDR_W'(1);
        if (fill_cnt == '0) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        cell_value_next = '0;
        state_next      = ST_DONE;
        case (req_kind)
          KIND_PUT: begin
            if (req_char inside {CH_LF, CH_CR}) begin
              cursor_column_next = '0;
              row_adv            = 1'b1;
            end else if (is_bs) begin
              if (cursor_column != '0) begin
                cursor_column_next = cursor_column - COL_W'(1);
                mem_we             = 1'b1;
                mem_wdata          = {req_attr, CH_SPACE};
              end
            end else begin
              mem_we = 1'b1;
              if (cursor_column == COL_W'(COLUMNS - 1)) begin
                cursor_column_next = '0;
                row_adv            = 1'b1;
              end else begin
                cursor_column_next = cursor_column + COL_W'(1);
              end
            end
            if (row_adv) begin
              if (cursor_row == ROW_W'(ROWS - 1)) begin
                // scroll: old top row becomes the blank bottom row
                top_base_next  = top_adv;
                fill_addr_next = top_base;
                fill_cnt_next  = ADDR_W'(COLUMNS - 1);
                fill_data_next = {blank_attribute, CH_SPACE};
                state_next     = ST_FILL;
              end else begin
                cursor_row_next = cursor_row + ROW_W'(1);
              end
            end
          end
          KIND_READ: begin
            if (idx_ok) begin
              state_next = ST_RDATA;
            end
          end
          KIND_CLEAR: begin
            cursor_column_next = '0;
            cursor_row_next    = '0;
            top_base_next      = '0;
            fill_addr_next     = '0;
            fill_cnt_next      = ADDR_W'(CELL_COUNT - 1);
            fill_data_next     = {blank_attribute, CH_SPACE};
            state_next         = ST_FILL;
          end
          default: begin
            // unused kind: no change
          end
        endcase
      end

      ST_RDATA: begin
        cell_value_next = rd_data;
        state_next      = ST_DONE;
      end

      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_addr;
        mem_wdata = fill_data;
        fill_addr_next = fill_addr + ADDR_W'(1);
        fill_cnt_next  = fill_cnt - ADDR_W'(1);
        if (fill_cnt == '0) begin
          state_next = ST_DONE;
        end
      end

      ST_DONE: begin
        // wait for the output register to free up
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_row    <= '0;
      top_base      <= '0;
      fill_addr     <= '0;
      fill_cnt      <= ADDR_W'(CELL_COUNT - 1);
      fill_data     <= {RESET_ATTR, CH_SPACE};
    end else begin
      cursor_column <= cursor_column_next;
      cursor_row    <= cursor_row_next;
      top_base      <= top_base_next;
      fill_addr     <= fill_addr_next;
      fill_cnt      <= fill_cnt_next;
      fill_data     <= fill_data_next;
    end
  end

  always_ff @(posedge clk) begin
    cell_value <= cell_value_next;
  end

  // ---------------- result register ----------------
  logic [POS_W-1:0] cursor_pos;
  assign cursor_pos = POS_W'(cur_lin);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {5'b0, cell_value, cursor_pos};
    end
  end

  // ---------------- checks ----------------
  `TCW_ASSERT_NOW(a_wr_in_range, mem_we, mem_waddr < CELL_COUNT, "cell write out of range")
  `TCW_ASSERT_NOW(a_cursor_range, 1'b1, (cursor_row < ROWS) && (cursor_column < COLUMNS), "cursor off screen")
  `TCW_ASSERT_NOW(a_top_range, 1'b1, top_base < CELL_COUNT, "row rotation base out of range")
  `TCW_ASSERT_NEXT(a_accept_exec, accept, state == ST_EXEC, "accepted request not executed")
  `TCW_ASSERT_NEXT(a_fill_ends, (state == ST_FILL) && (fill_cnt == '0), state == ST_DONE, "fill sweep overran")

endmodule

`default_nettype wire

/* sv/tcw_apb_regs.sv */
`default_nettype none

module tcw_apb_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tcw_pkg::PADDR_W-1:0] paddr,
  input  wire logic [tcw_pkg::PDATA_W-1:0] pwdata,
  output logic      [tcw_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  output logic      [tcw_pkg::BYTE_W-1:0]  blank_attribute
);
  import tcw_pkg::*;

  logic reg_hit;
  logic wr_en;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_BLANK_ATTR);
  assign wr_en   = psel && penable && pwrite && pready && reg_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      blank_attribute <= RESET_ATTR;
    end else if (wr_en) begin
      blank_attribute <= pwdata[BYTE_W-1:0];
    end
  end

  assign prdata = reg_hit ? PDATA_W'(blank_attribute) : '0;

endmodule

`default_nettype wire
